[hw/rtl/ldq_pkg.sv]
// Shared types, codes and constants for the linked deque with free list.
`timescale 1ns / 1ps

package ldq_pkg;

  // Node pointers are six bits wide; the all-ones code marks a null link.
  localparam int PTR_W = 6;
  localparam logic [PTR_W-1:0] NULL_PTR = 6'd63;

  // Default pool size and the longest listing one command may produce.
  localparam int POOL_NODES_DEF = 32;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W = $clog2(MAX_RESULTS);

  // Command codes.
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_LIST_FWD   = 3'd4;
  localparam logic [2:0] CMD_LIST_BWD   = 3'd5;
  localparam logic [2:0] CMD_LIST_FREE  = 3'd6;
  localparam logic [2:0] CMD_NOP        = 3'd7;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // One input beat.
  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] value;
  } ldq_in_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] item;
    logic               last;
  } ldq_out_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE_FRESH,
    OP_FREE_RD,
    OP_FREE_POP,
    OP_LINK,
    OP_LINK_END,
    OP_END_RD,
    OP_UNLINK,
    OP_GIVE,
    OP_WALK_START,
    OP_WALK_RD,
    OP_WALK_EMIT,
    OP_EMIT_ERR
  } ldq_op_t;

  // Controller to datapath.
  typedef struct packed {
    logic       load;
    ldq_op_t    op;
    logic [1:0] err_status;
  } ldq_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] cmd;
    logic       free_ok;
    logic       fresh_ok;
    logic       end_ok;
    logic       start_ok;
    logic       walk_fin;
  } ldq_stat_t;

endpackage

[hw/rtl/ldq_ctrl.sv]
// Command sequencer for the linked deque: walks each command through its steps.
`timescale 1ns / 1ps

module ldq_ctrl
  import ldq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  ldq_stat_t stat,
  output ldq_ctl_t  ctl
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_FREE_POP,
    S_LINK,
    S_LINK_END,
    S_UNLINK,
    S_GIVE,
    S_WALK_RD,
    S_WALK_EMIT
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  // Next state and the datapath operation for this cycle.
  always_comb begin
    state_nxt      = state_r;
    ctl.load       = 1'b0;
    ctl.op         = OP_NONE;
    ctl.err_status = ST_EMPTY;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.cmd)
          CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            // Reuse a freed node first, then a never-used one.
            if (stat.free_ok) begin
              ctl.op    = OP_FREE_RD;
              state_nxt = S_FREE_POP;
            end else if (stat.fresh_ok) begin
              ctl.op    = OP_TAKE_FRESH;
              state_nxt = S_LINK;
            end else begin
              ctl.op         = OP_EMIT_ERR;
              ctl.err_status = ST_FULL;
              state_nxt      = S_IDLE;
            end
          end
          CMD_POP_FRONT, CMD_POP_BACK: begin
            if (stat.end_ok) begin
              ctl.op    = OP_END_RD;
              state_nxt = S_UNLINK;
            end else begin
              ctl.op    = OP_EMIT_ERR;
              state_nxt = S_IDLE;
            end
          end
          CMD_LIST_FWD, CMD_LIST_BWD, CMD_LIST_FREE: begin
            if (stat.start_ok) begin
              ctl.op    = OP_WALK_START;
              state_nxt = S_WALK_RD;
            end else begin
              ctl.op    = OP_EMIT_ERR;
              state_nxt = S_IDLE;
            end
          end
          default: begin
            // Unused command code: no result.
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_FREE_POP: begin
        ctl.op    = OP_FREE_POP;
        state_nxt = S_LINK;
      end
      S_LINK: begin
        ctl.op    = OP_LINK;
        state_nxt = S_LINK_END;
      end
      S_LINK_END: begin
        ctl.op    = OP_LINK_END;
        state_nxt = S_IDLE;
      end
      S_UNLINK: begin
        ctl.op    = OP_UNLINK;
        state_nxt = S_GIVE;
      end
      S_GIVE: begin
        ctl.op    = OP_GIVE;
        state_nxt = S_IDLE;
      end
      S_WALK_RD: begin
        ctl.op    = OP_WALK_RD;
        state_nxt = S_WALK_EMIT;
      end
      S_WALK_EMIT: begin
        ctl.op    = OP_WALK_EMIT;
        state_nxt = stat.walk_fin ? S_IDLE : S_WALK_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[hw/rtl/ldq_dpath.sv]
// Node pool memories, list pointers and result register of the linked deque.
`timescale 1ns / 1ps

module ldq_dpath
  import ldq_pkg::*;
#(
  parameter int POOL_NODES = POOL_NODES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ldq_in_t   in_data,
  input  ldq_ctl_t  ctl,
  output ldq_stat_t stat,
  output logic      out_valid,
  output ldq_out_t  out_data
);

  localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam logic [PTR_W-1:0] POOL_PTR = PTR_W'(POOL_NODES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RESULTS - 1);

  // Node pool: value, previous link and next link, one entry per node.
  logic signed [31:0] mem_value [POOL_NODES];
  logic [PTR_W-1:0]   mem_prev  [POOL_NODES];
  logic [PTR_W-1:0]   mem_next  [POOL_NODES];

  logic signed [31:0] rd_value_r;
  logic [PTR_W-1:0]   rd_prev_r, rd_next_r;

  logic [PTR_W-1:0]   front_r, back_r, free_r, fresh_r;
  logic [PTR_W-1:0]   cur_r;
  logic [2:0]         cmd_r;
  logic signed [31:0] val_r;
  logic [CNT_W-1:0]   cnt_r;

  logic               out_valid_r;
  ldq_out_t           out_r;

  function automatic logic is_node(input logic [PTR_W-1:0] p);
    return p < POOL_PTR;
  endfunction

  function automatic logic [AW-1:0] idx(input logic [PTR_W-1:0] p);
    return p[AW-1:0];
  endfunction

  logic [PTR_W-1:0] walk_nx;
  logic [PTR_W-1:0] walk_start;
  logic             is_front;

  assign is_front = (cmd_r == CMD_PUSH_FRONT) || (cmd_r == CMD_POP_FRONT);
  assign walk_nx  = (cmd_r == CMD_LIST_BWD) ? rd_prev_r : rd_next_r;

  // Starting pointer of a listing.
  always_comb begin
    unique case (cmd_r)
      CMD_LIST_FWD: walk_start = front_r;
      CMD_LIST_BWD: walk_start = back_r;
      default:      walk_start = free_r;
    endcase
  end

  // Status for the controller.
  always_comb begin
    stat.cmd      = cmd_r;
    stat.free_ok  = is_node(free_r);
    stat.fresh_ok = fresh_r < POOL_PTR;
    stat.end_ok   = is_node(is_front ? front_r : back_r);
    stat.start_ok = is_node(walk_start);
    stat.walk_fin = !is_node(walk_nx) || (cnt_r == CNT_LAST);
  end

  // Memory port control: one read address, one write per memory per cycle.
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic             val_we;
  logic             prev_we, next_we;
  logic [PTR_W-1:0] prev_wa, prev_wd, next_wa, next_wd;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur_r;
    val_we  = 1'b0;
    prev_we = 1'b0;
    prev_wa = cur_r;
    prev_wd = NULL_PTR;
    next_we = 1'b0;
    next_wa = cur_r;
    next_wd = NULL_PTR;
    unique case (ctl.op)
      OP_FREE_RD: begin
        rd_en   = 1'b1;
        rd_addr = free_r;
      end
      OP_END_RD: begin
        rd_en   = 1'b1;
        rd_addr = is_front ? front_r : back_r;
      end
      OP_WALK_RD: begin
        rd_en = 1'b1;
      end
      OP_LINK: begin
        // New node: value and both links written together.
        val_we  = 1'b1;
        prev_we = 1'b1;
        next_we = 1'b1;
        prev_wd = is_front ? NULL_PTR : back_r;
        next_wd = is_front ? front_r : NULL_PTR;
      end
      OP_LINK_END: begin
        // Point the old end node back at the new one.
        if (is_front) begin
          prev_we = is_node(front_r);
          prev_wa = front_r;
          prev_wd = cur_r;
        end else begin
          next_we = is_node(back_r);
          next_wa = back_r;
          next_wd = cur_r;
        end
      end
      OP_UNLINK: begin
        // The new end node loses its link to the removed one.
        if (is_front) begin
          prev_we = is_node(rd_next_r);
          prev_wa = rd_next_r;
        end else begin
          next_we = is_node(rd_prev_r);
          next_wa = rd_prev_r;
        end
      end
      OP_GIVE: begin
        next_we = 1'b1;
        next_wd = free_r;
      end
      default: begin
      end
    endcase
  end

  // Node pool memories with registered read data.
  always_ff @(posedge clk) begin
    if (val_we) begin
      mem_value[idx(cur_r)] <= val_r;
    end
    if (prev_we) begin
      mem_prev[idx(prev_wa)] <= prev_wd;
    end
    if (next_we) begin
      mem_next[idx(next_wa)] <= next_wd;
    end
    if (rd_en) begin
      rd_value_r <= mem_value[idx(rd_addr)];
      rd_prev_r  <= mem_prev[idx(rd_addr)];
      rd_next_r  <= mem_next[idx(rd_addr)];
    end
  end

  // List pointers and the count of nodes taken fresh so far.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= NULL_PTR;
      back_r  <= NULL_PTR;
      free_r  <= NULL_PTR;
      fresh_r <= '0;
    end else begin
      unique case (ctl.op)
        OP_TAKE_FRESH: fresh_r <= fresh_r + 1'b1;
        OP_FREE_POP:   free_r  <= rd_next_r;
        OP_LINK_END: begin
          if (is_front) begin
            front_r <= cur_r;
            if (!is_node(front_r)) begin
              back_r <= cur_r;
            end
          end else begin
            back_r <= cur_r;
            if (!is_node(back_r)) begin
              front_r <= cur_r;
            end
          end
        end
        OP_UNLINK: begin
          if (is_front) begin
            front_r <= rd_next_r;
            if (!is_node(rd_next_r)) begin
              back_r <= NULL_PTR;
            end
          end else begin
            back_r <= rd_prev_r;
            if (!is_node(rd_prev_r)) begin
              front_r <= NULL_PTR;
            end
          end
        end
        OP_GIVE: free_r <= cur_r;
        default: begin
        end
      endcase
    end
  end

  // Command, value, working pointer and listing count.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= in_data.cmd;
      val_r <= in_data.value;
    end
    unique case (ctl.op)
      OP_TAKE_FRESH: cur_r <= fresh_r;
      OP_FREE_RD:    cur_r <= free_r;
      OP_END_RD:     cur_r <= is_front ? front_r : back_r;
      OP_UNLINK:     val_r <= rd_value_r;
      OP_WALK_START: begin
        cur_r <= walk_start;
        cnt_r <= '0;
      end
      OP_WALK_EMIT: begin
        cur_r <= walk_nx;
        cnt_r <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Result register: one beat per strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (ctl.op == OP_LINK_END) || (ctl.op == OP_GIVE) ||
                     (ctl.op == OP_WALK_EMIT) || (ctl.op == OP_EMIT_ERR);
    end
    unique case (ctl.op)
      OP_LINK_END, OP_GIVE: begin
        out_r.status <= ST_OK;
        out_r.item   <= val_r;
        out_r.last   <= 1'b1;
      end
      OP_WALK_EMIT: begin
        out_r.status <= ST_OK;
        out_r.item   <= rd_value_r;
        out_r.last   <= stat.walk_fin;
      end
      OP_EMIT_ERR: begin
        out_r.status <= ctl.err_status;
        out_r.item   <= '0;
        out_r.last   <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[hw/rtl/linked_deque_with_free_list.sv]
// A push takes a node (popping the free list first when it reuses a freed node), writes it
// and links the old end node back to it; a pop reads the end node, unlinks it and frees it;
// a failed push or pop emits its error from decode. A listing reads, then emits, each node,
// as each step of the walk waits on the registered read port of the node pool memories.
// Reset empties the deque and the free list and marks every node unused; the pool
// memories are not cleared. The receiver cannot stall: each result stands one cycle.
`timescale 1ns / 1ps

module linked_deque_with_free_list
  import ldq_pkg::*;
#(
  parameter int POOL_NODES = POOL_NODES_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ldq_in_t  in_data,
  output logic     out_valid,
  output ldq_out_t out_data
);

  ldq_ctl_t  ctl;
  ldq_stat_t stat;

  // Command sequencer.
  ldq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctl   (ctl)
  );

  // Node pool and pointers.
  ldq_dpath #(
    .POOL_NODES (POOL_NODES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[hw/rtl/ldq_checker.sv]
// Port-level checks for the linked deque, bound to the top level.
`timescale 1ns / 1ps

module ldq_checker
  import ldq_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input ldq_out_t out_data
);

  // No result beat right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // An accepted command keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // A listing that is not finished keeps the block busy.
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |-> busy)
    else $error("unfinished listing with busy low");

  // Listing beats never come back to back.
  a_walk_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last) |=> !out_valid)
    else $error("listing beats back to back");

  // Error beats carry a zero item and end the command.
  a_err_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status != ST_OK)) |-> (out_data.item == '0 && out_data.last))
    else $error("error beat with item or without last");

endmodule

bind linked_deque_with_free_list ldq_checker u_ldq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);

[dv/linked_deque_with_free_list_test.sv]
// Self-checking testbench for the linked deque: directed corners, then biased random traffic.
`timescale 1ns / 1ps

module linked_deque_with_free_list_test
  import ldq_pkg::*;
();

  localparam int POOL = POOL_NODES_DEF;
  localparam int RANDOM_ITEMS = 480;
  localparam int PHASE_LEN = 48;
  localparam int CYCLE_LIMIT = 200000;
  // Allow time for the longest listing to stream out, with some margin.
  localparam int DRAIN_CYCLES = 2 + 2 * MAX_RESULTS + 8;

  // Tracks the deque, its links and the free list, and checks each result beat in order.
  class deque_scoreboard;
    logic [31:0]      node_val[POOL];
    logic [PTR_W-1:0] link_prev[POOL];
    logic [PTR_W-1:0] link_next[POOL];
    logic [PTR_W-1:0] front;
    logic [PTR_W-1:0] back;
    logic [PTR_W-1:0] free_top;
    int               fresh_used;
    ldq_out_t         pending_results[$];
    int               mismatches;

    function new();
      foreach (node_val[i]) begin
        node_val[i] = '0;
        link_prev[i] = NULL_PTR;
        link_next[i] = NULL_PTR;
      end
      front = NULL_PTR;
      back = NULL_PTR;
      free_top = NULL_PTR;
      fresh_used = 0;
      mismatches = 0;
    endfunction

    function bit in_pool(logic [PTR_W-1:0] p);
      return p < POOL;
    endfunction

    function void add_result(logic [1:0] status, logic [31:0] item, bit last);
      ldq_out_t beat;
      beat.status = status;
      beat.item = item;
      beat.last = last;
      pending_results.push_back(beat);
    endfunction

    // Freed nodes come back first, newest first; then never-used nodes in index order.
    function logic [PTR_W-1:0] alloc_node();
      logic [PTR_W-1:0] n;
      if (in_pool(free_top)) begin
        n = free_top;
        free_top = link_next[n];
        return n;
      end
      if (fresh_used < POOL) begin
        n = PTR_W'(fresh_used);
        fresh_used++;
        return n;
      end
      return NULL_PTR;
    endfunction

    // Unlinks the front or back node, reports its value and puts it on the free list.
    function void remove_end(bit at_front);
      logic [PTR_W-1:0] n;
      n = at_front ? front : back;
      if (!in_pool(n)) begin
        add_result(ST_EMPTY, '0, 1'b1);
        return;
      end
      add_result(ST_OK, node_val[n], 1'b1);
      if (at_front) begin
        front = link_next[n];
        if (in_pool(front)) link_prev[front] = NULL_PTR;
        else back = NULL_PTR;
      end else begin
        back = link_prev[n];
        if (in_pool(back)) link_next[back] = NULL_PTR;
        else front = NULL_PTR;
      end
      link_next[n] = free_top;
      free_top = n;
    endfunction

    // Walks a chain of links; the walk is cut at the result limit with the last beat marked.
    function void walk_list(logic [PTR_W-1:0] head, bit use_prev);
      logic [PTR_W-1:0] p;
      logic [PTR_W-1:0] nx;
      int               k;
      p = head;
      k = 0;
      if (!in_pool(p)) begin
        add_result(ST_EMPTY, '0, 1'b1);
        return;
      end
      while (in_pool(p) && k < MAX_RESULTS) begin
        nx = use_prev ? link_prev[p] : link_next[p];
        add_result(ST_OK, node_val[p], !in_pool(nx) || k + 1 == MAX_RESULTS);
        k++;
        p = nx;
      end
    endfunction

    // Applies one accepted command and queues the beats it must produce.
    function void note_command(ldq_in_t cmd_beat);
      logic [PTR_W-1:0] n;
      case (cmd_beat.cmd)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          n = alloc_node();
          if (!in_pool(n)) begin
            add_result(ST_FULL, '0, 1'b1);
          end else begin
            node_val[n] = cmd_beat.value;
            if (cmd_beat.cmd == CMD_PUSH_FRONT) begin
              link_prev[n] = NULL_PTR;
              link_next[n] = front;
              if (in_pool(front)) link_prev[front] = n;
              else back = n;
              front = n;
            end else begin
              link_next[n] = NULL_PTR;
              link_prev[n] = back;
              if (in_pool(back)) link_next[back] = n;
              else front = n;
              back = n;
            end
            add_result(ST_OK, cmd_beat.value, 1'b1);
          end
        end
        CMD_POP_FRONT: remove_end(1'b1);
        CMD_POP_BACK:  remove_end(1'b0);
        CMD_LIST_FWD:  walk_list(front, 1'b0);
        CMD_LIST_BWD:  walk_list(back, 1'b1);
        CMD_LIST_FREE: walk_list(free_top, 1'b0);
        default: ;
      endcase
    endfunction

    // Compares one result beat with the oldest outstanding expectation.
    function void check_result(ldq_out_t got);
      ldq_out_t want;
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: status %0d item %0d last %0d",
               got.status, got.item, got.last);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.item !== want.item) begin
        $error("item: expected %0d, got %0d", want.item, got.item);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  ldq_in_t  in_data;
  logic     out_valid;
  ldq_out_t out_data;

  deque_scoreboard board;
  bit              no_gaps;

  linked_deque_with_free_list DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every result beat stands for one cycle and is checked at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_result(out_data);
  end

  // Hard stop in case the block hangs or drops results.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // Offers one command beat, waits until it is taken, then draws the gap to the next one.
  task automatic send_command(logic [2:0] cmd, logic [31:0] value);
    ldq_in_t cmd_beat;
    int      gap;
    cmd_beat.cmd = cmd;
    cmd_beat.value = value;
    start <= 1'b1;
    in_data <= cmd_beat;
    do @(posedge clk); while (busy);
    board.note_command(cmd_beat);
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (board.pending_results.size() != 0) @(posedge clk);
  endtask

  // Mostly random data, with the signed extremes, zero and minus one mixed in.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Push share in percent sets whether the deque tends to grow, churn or drain.
  function automatic logic [2:0] pick_command(int push_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return CMD_NOP;
    if (r < 12) begin
      case ($urandom_range(0, 2))
        0: return CMD_LIST_FWD;
        1: return CMD_LIST_BWD;
        default: return CMD_LIST_FREE;
      endcase
    end
    if ($urandom_range(0, 99) < push_pct) begin
      return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    end
    return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
  endfunction

  initial begin
    logic [2:0] cmd;
    int         sent;
    int         push_pct;
    board = new();
    no_gaps = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty deque and empty free list, then an ignored code.
    send_command(CMD_POP_FRONT, 32'h1234_5678);
    send_command(CMD_POP_BACK, 32'h0);
    send_command(CMD_LIST_FWD, 32'h0);
    send_command(CMD_LIST_BWD, 32'h0);
    send_command(CMD_LIST_FREE, 32'h0);
    send_command(CMD_NOP, 32'hffff_ffff);
    // Extremes at both ends, then listings both ways.
    send_command(CMD_PUSH_FRONT, 32'h7fff_ffff);
    send_command(CMD_PUSH_BACK, 32'h8000_0000);
    send_command(CMD_PUSH_FRONT, 32'hffff_ffff);
    send_command(CMD_PUSH_BACK, 32'h0000_0000);
    send_command(CMD_LIST_FWD, 32'h0);
    send_command(CMD_LIST_BWD, 32'h0);
    // Pops free nodes; the free listing shows their old values, newest first.
    send_command(CMD_POP_FRONT, 32'h0);
    send_command(CMD_POP_BACK, 32'h0);
    send_command(CMD_LIST_FREE, 32'h0);
    send_command(CMD_PUSH_BACK, 32'h5555_aaaa);
    send_command(CMD_LIST_FREE, 32'h0);
    send_command(CMD_LIST_FWD, 32'h0);
    // Drain to empty so both pointers fall back to null.
    send_command(CMD_POP_BACK, 32'h0);
    send_command(CMD_POP_BACK, 32'h0);
    send_command(CMD_POP_FRONT, 32'h0);
    send_command(CMD_POP_FRONT, 32'h0);
    send_command(CMD_LIST_BWD, 32'h0);
    send_command(CMD_LIST_FREE, 32'h0);

    // Let the block go fully quiet before the random traffic starts.
    wait_for_results();
    repeat (2) @(posedge clk);

    // Phases cycle through fill, churn, drain and a random mix, so the pool runs
    // full, long listings hit the result limit and the free list grows and shrinks.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ((sent / PHASE_LEN) % 4)
        0: push_pct = 95;
        1: push_pct = 50;
        2: push_pct = 8;
        default: push_pct = $urandom_range(20, 80);
      endcase
      if (sent % PHASE_LEN == 0) no_gaps = ($urandom_range(0, 3) == 0);
      cmd = pick_command(push_pct);
      send_command(cmd, pick_value());
      if (cmd != CMD_NOP) sent++;
    end

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
